// ===== rtl/core/bmhq_pkg.sv =====
// Shared constants, entry type and codes for the binary min-heap queue.
package bmhq_pkg;

  localparam int unsigned CAPACITY     = 16;
  localparam int unsigned KEY_BITS     = 32;
  localparam int unsigned PAYLOAD_BITS = 16;

  // heap index, fill count, and child index wide enough for 2*pos+2
  localparam int unsigned IDX_W = $clog2(CAPACITY);
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned LFT_W = IDX_W + 2;

  typedef logic [KEY_BITS-1:0]     key_t;
  typedef logic [PAYLOAD_BITS-1:0] pay_t;
  typedef logic [IDX_W-1:0]        idx_t;
  typedef logic [CNT_W-1:0]        cnt_t;
  typedef logic [LFT_W-1:0]        lft_t;

  typedef struct packed {
    key_t key;
    pay_t pay;
  } entry_t;

  typedef enum logic {
    OP_INSERT  = 1'b0,
    OP_EXTRACT = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_EMPTY = 2'd1,
    ERR_FULL  = 2'd2
  } err_e;

endpackage

// ===== rtl/core/binary_min_heap_queue_top.sv =====
// Binary min-heap priority queue: heap memory, sift sequencer and result register.
//
//   channel  handshake              fields
//   req      req_valid_i/ready_o    operation_i, key_i, payload_i
//   res      res_valid_o/ready_i    out_valid_o, out_key_o, out_payload_o, error_o,
//                                   entry_count_o, min_key_o, min_payload_o, empty_res_o
//
// One item at a time through a 2-read/1-write heap memory with registered reads;
// each sift level passes a check state and a compare state. An insert walks up from
// the new leaf; an extract reads the root and last entry, then sifts down; errors go
// straight to the root read and the result. Reset clears the count and control only.
// A waiting result does not block the next item; that item's result is held back
// until the previous one is taken.
module binary_min_heap_queue_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              req_valid_i,
  output logic                              req_ready_o,
  input  logic                              operation_i,
  input  logic [bmhq_pkg::KEY_BITS-1:0]     key_i,
  input  logic [bmhq_pkg::PAYLOAD_BITS-1:0] payload_i,
  output logic                              res_valid_o,
  input  logic                              res_ready_i,
  output logic                              out_valid_o,
  output logic [bmhq_pkg::KEY_BITS-1:0]     out_key_o,
  output logic [bmhq_pkg::PAYLOAD_BITS-1:0] out_payload_o,
  output logic [1:0]                        error_o,
  output logic [bmhq_pkg::CNT_W-1:0]        entry_count_o,
  output logic [bmhq_pkg::KEY_BITS-1:0]     min_key_o,
  output logic [bmhq_pkg::PAYLOAD_BITS-1:0] min_payload_o,
  output logic                              empty_res_o
);

  typedef enum logic [8:0] {
    S_IDLE    = 9'b000000001,
    S_UP_CHK  = 9'b000000010,
    S_UP_CMP  = 9'b000000100,
    S_EX_RD   = 9'b000001000,
    S_EX_CAP  = 9'b000010000,
    S_DN_CHK  = 9'b000100000,
    S_DN_CMP  = 9'b001000000,
    S_ROOT_RD = 9'b010000000,
    S_RES     = 9'b100000000
  } state_e;

  state_e                 state_q, state_d;
  bmhq_pkg::cnt_t         count_q, count_d;
  bmhq_pkg::idx_t         pos_q, pos_d;
  bmhq_pkg::entry_t       item_q, item_d;
  bmhq_pkg::entry_t       ext_q, ext_d;
  logic                   op_q, op_d;
  bmhq_pkg::err_e         err_q, err_d;

  bmhq_pkg::entry_t       heap_mem_q [bmhq_pkg::CAPACITY];
  bmhq_pkg::entry_t       rd0_q, rd1_q;
  bmhq_pkg::idx_t         ra0, ra1, wa;
  bmhq_pkg::entry_t       wd;
  logic                   we;

  logic                   load_res;
  logic                   res_valid_q;
  logic                   res_out_valid_q;
  bmhq_pkg::entry_t       res_ext_q;
  bmhq_pkg::err_e         res_err_q;
  bmhq_pkg::cnt_t         res_count_q;
  bmhq_pkg::entry_t       res_min_q;

  bmhq_pkg::lft_t         lft, rgt, cnt_ext;
  bmhq_pkg::idx_t         parent;
  logic                   lt_l, take_r;
  bmhq_pkg::key_t         best_key;

  assign req_ready_o = (state_q == S_IDLE);

  // child and parent positions of the hole
  assign lft     = bmhq_pkg::LFT_W'({pos_q, 1'b0}) + bmhq_pkg::LFT_W'(1);
  assign rgt     = lft + bmhq_pkg::LFT_W'(1);
  assign cnt_ext = bmhq_pkg::LFT_W'(count_q);
  assign parent  = (pos_q - bmhq_pkg::IDX_W'(1)) >> 1;

  // sift-down compare: smallest of moving item, left child, right child (ties keep the item, then left)
  assign lt_l     = (rd0_q.key < item_q.key);
  assign best_key = lt_l ? rd0_q.key : item_q.key;
  assign take_r   = (rgt < cnt_ext) && (rd1_q.key < best_key);

  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    pos_d    = pos_q;
    item_d   = item_q;
    ext_d    = ext_q;
    op_d     = op_q;
    err_d    = err_q;
    we       = 1'b0;
    wa       = pos_q;
    wd       = item_q;
    ra0      = '0;
    ra1      = '0;
    load_res = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          item_d = '{key: key_i, pay: payload_i};
          op_d   = operation_i;
          ext_d  = '0;
          err_d  = bmhq_pkg::ERR_NONE;
          if (operation_i == bmhq_pkg::OP_EXTRACT) begin
            if (count_q == '0) begin
              err_d   = bmhq_pkg::ERR_EMPTY;
              state_d = S_ROOT_RD;
            end else begin
              state_d = S_EX_RD;
            end
          end else begin
            if (count_q == bmhq_pkg::CNT_W'(bmhq_pkg::CAPACITY)) begin
              err_d   = bmhq_pkg::ERR_FULL;
              state_d = S_ROOT_RD;
            end else begin
              pos_d   = count_q[bmhq_pkg::IDX_W-1:0];
              count_d = count_q + bmhq_pkg::CNT_W'(1);
              state_d = S_UP_CHK;
            end
          end
        end
      end

      S_UP_CHK: begin
        if (pos_q == '0) begin
          we      = 1'b1;
          state_d = S_ROOT_RD;
        end else begin
          ra0     = parent;
          state_d = S_UP_CMP;
        end
      end

      S_UP_CMP: begin
        we = 1'b1;
        if (rd0_q.key > item_q.key) begin
          // parent moves down into the hole
          wd      = rd0_q;
          pos_d   = parent;
          state_d = S_UP_CHK;
        end else begin
          state_d = S_ROOT_RD;
        end
      end

      S_EX_RD: begin
        ra0     = '0;
        ra1     = bmhq_pkg::IDX_W'(count_q - bmhq_pkg::CNT_W'(1));
        count_d = count_q - bmhq_pkg::CNT_W'(1);
        state_d = S_EX_CAP;
      end

      S_EX_CAP: begin
        ext_d   = rd0_q;
        item_d  = rd1_q;
        pos_d   = '0;
        state_d = S_DN_CHK;
      end

      S_DN_CHK: begin
        if (lft >= cnt_ext) begin
          we      = 1'b1;
          state_d = S_ROOT_RD;
        end else begin
          ra0     = lft[bmhq_pkg::IDX_W-1:0];
          ra1     = rgt[bmhq_pkg::IDX_W-1:0];
          state_d = S_DN_CMP;
        end
      end

      S_DN_CMP: begin
        we = 1'b1;
        if (take_r) begin
          wd      = rd1_q;
          pos_d   = rgt[bmhq_pkg::IDX_W-1:0];
          state_d = S_DN_CHK;
        end else if (lt_l) begin
          wd      = rd0_q;
          pos_d   = lft[bmhq_pkg::IDX_W-1:0];
          state_d = S_DN_CHK;
        end else begin
          state_d = S_ROOT_RD;
        end
      end

      S_ROOT_RD: begin
        // ra0 stays at the root so rd0_q holds it through S_RES
        state_d = S_RES;
      end

      S_RES: begin
        if (!res_valid_q || res_ready_i) begin
          load_res = 1'b1;
          state_d  = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (load_res) begin
        res_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q  <= pos_d;
    item_q <= item_d;
    ext_q  <= ext_d;
    op_q   <= op_d;
    err_q  <= err_d;
  end

  // heap memory: one write, two registered reads
  always_ff @(posedge clk_i) begin
    if (we) begin
      heap_mem_q[wa] <= wd;
    end
    rd0_q <= heap_mem_q[ra0];
    rd1_q <= heap_mem_q[ra1];
  end

  always_ff @(posedge clk_i) begin
    if (load_res) begin
      res_out_valid_q <= (op_q == bmhq_pkg::OP_EXTRACT) && (err_q == bmhq_pkg::ERR_NONE);
      res_ext_q       <= ext_q;
      res_err_q       <= err_q;
      res_count_q     <= count_q;
      res_min_q       <= (count_q == '0) ? '0 : rd0_q;
    end
  end

  assign res_valid_o   = res_valid_q;
  assign out_valid_o   = res_out_valid_q;
  assign out_key_o     = res_ext_q.key;
  assign out_payload_o = res_ext_q.pay;
  assign error_o       = res_err_q;
  assign entry_count_o = res_count_q;
  assign min_key_o     = res_min_q.key;
  assign min_payload_o = res_min_q.pay;
  assign empty_res_o   = (res_count_q == '0);

endmodule

// ===== bench/binary_min_heap_queue_top_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the binary min-heap priority queue.
module binary_min_heap_queue_top_tb;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int          RANDOM_ITEMS = 1800;
  localparam int          HOLD_CYCLES = 300;

  typedef struct {
    logic           out_valid;
    bmhq_pkg::key_t out_key;
    bmhq_pkg::pay_t out_pay;
    bmhq_pkg::err_e err;
    bmhq_pkg::cnt_t count;
    bmhq_pkg::key_t min_key;
    bmhq_pkg::pay_t min_pay;
    logic           empty;
  } heap_result_t;

  // Heap predictor plus the list of results still owed by the block.
  class heap_checker;
    bmhq_pkg::key_t keys[bmhq_pkg::CAPACITY];
    bmhq_pkg::pay_t pays[bmhq_pkg::CAPACITY];
    int             fill;
    int             mismatches;
    heap_result_t   pending_results[$];

    function new();
      fill = 0;
      mismatches = 0;
    endfunction

    function void swap_entries(int a, int b);
      bmhq_pkg::key_t k;
      bmhq_pkg::pay_t p;
      k = keys[a];
      p = pays[a];
      keys[a] = keys[b];
      pays[a] = pays[b];
      keys[b] = k;
      pays[b] = p;
    endfunction

    function void note_request(bmhq_pkg::op_e op, bmhq_pkg::key_t key, bmhq_pkg::pay_t pay);
      heap_result_t r;
      int pos, up, lft, best;
      r.out_valid = 1'b0;
      r.out_key   = '0;
      r.out_pay   = '0;
      r.err       = bmhq_pkg::ERR_NONE;
      if (op == bmhq_pkg::OP_INSERT) begin
        if (fill >= bmhq_pkg::CAPACITY) begin
          r.err = bmhq_pkg::ERR_FULL;
        end else begin
          keys[fill] = key;
          pays[fill] = pay;
          pos = fill;
          fill++;
          // sift up only while the parent is strictly greater
          while (pos > 0) begin
            up = (pos - 1) / 2;
            if (keys[up] <= keys[pos]) break;
            swap_entries(up, pos);
            pos = up;
          end
        end
      end else if (fill == 0) begin
        r.err = bmhq_pkg::ERR_EMPTY;
      end else begin
        r.out_valid = 1'b1;
        r.out_key   = keys[0];
        r.out_pay   = pays[0];
        fill--;
        keys[0] = keys[fill];
        pays[0] = pays[fill];
        pos = 0;
        // left child wins a tie; swap only on strictly smaller
        while (1) begin
          lft  = 2 * pos + 1;
          best = pos;
          if (lft >= fill) break;
          if (keys[lft] < keys[best]) best = lft;
          if (lft + 1 < fill && keys[lft + 1] < keys[best]) best = lft + 1;
          if (best == pos) break;
          swap_entries(pos, best);
          pos = best;
        end
      end
      r.count   = bmhq_pkg::cnt_t'(fill);
      r.min_key = (fill > 0) ? keys[0] : '0;
      r.min_pay = (fill > 0) ? pays[0] : '0;
      r.empty   = (fill == 0);
      pending_results.push_back(r);
    endfunction

    task report(string what, logic [63:0] got, logic [63:0] want);
      if (mismatches < 25)
        $display("%0t MISMATCH %s: got %0h, expected %0h", $realtime, what, got, want);
      mismatches++;
    endtask

    task check_result(logic ov, bmhq_pkg::key_t ok, bmhq_pkg::pay_t op, logic [1:0] er,
                      bmhq_pkg::cnt_t cnt, bmhq_pkg::key_t mk, bmhq_pkg::pay_t mp,
                      logic emp);
      heap_result_t w;
      if (pending_results.size() == 0) begin
        report("result with no item pending", 64'd1, 64'd0);
        return;
      end
      w = pending_results.pop_front();
      if (ov !== w.out_valid) report("out_valid", ov, w.out_valid);
      if (ok !== w.out_key)   report("out_key", ok, w.out_key);
      if (op !== w.out_pay)   report("out_payload", op, w.out_pay);
      if (er !== w.err)       report("error", er, w.err);
      if (cnt !== w.count)    report("entry_count", cnt, w.count);
      if (mk !== w.min_key)   report("min_key", mk, w.min_key);
      if (mp !== w.min_pay)   report("min_payload", mp, w.min_pay);
      if (emp !== w.empty)    report("empty_res", emp, w.empty);
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic req_valid_i = 1'b0;
  logic req_ready_o;
  logic operation_i = 1'b0;
  bmhq_pkg::key_t key_i = '0;
  bmhq_pkg::pay_t payload_i = '0;
  logic res_valid_o;
  logic res_ready_i = 1'b0;
  logic out_valid_o;
  bmhq_pkg::key_t out_key_o;
  bmhq_pkg::pay_t out_payload_o;
  logic [1:0] error_o;
  bmhq_pkg::cnt_t entry_count_o;
  bmhq_pkg::key_t min_key_o;
  bmhq_pkg::pay_t min_payload_o;
  logic empty_res_o;

  heap_checker sb = new();
  int req_count = 0;
  int res_count = 0;
  int unsigned cycles = 0;

  binary_min_heap_queue_top uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_valid_i   (req_valid_i),
    .req_ready_o   (req_ready_o),
    .operation_i   (operation_i),
    .key_i         (key_i),
    .payload_i     (payload_i),
    .res_valid_o   (res_valid_o),
    .res_ready_i   (res_ready_i),
    .out_valid_o   (out_valid_o),
    .out_key_o     (out_key_o),
    .out_payload_o (out_payload_o),
    .error_o       (error_o),
    .entry_count_o (entry_count_o),
    .min_key_o     (min_key_o),
    .min_payload_o (min_payload_o),
    .empty_res_o   (empty_res_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // result is checked before the new item is noted; it can never be that item's
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (res_valid_o && res_ready_i) begin
        sb.check_result(out_valid_o, out_key_o, out_payload_o, error_o, entry_count_o,
                        min_key_o, min_payload_o, empty_res_o);
        res_count <= res_count + 1;
      end
      if (req_valid_i && req_ready_o) begin
        sb.note_request(bmhq_pkg::op_e'(operation_i), key_i, payload_i);
        req_count <= req_count + 1;
      end
    end
  end

  // receiver: free-running or random stretches, short stalls, and long holds
  int  hold_left = 0;
  int  stall_left = 0;
  int  ready_stretch = 0;
  int  next_hold_at = 500;
  bit  ready_free = 1'b1;

  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      res_ready_i <= 1'b0;
    end else if (req_count >= next_hold_at) begin
      hold_left <= HOLD_CYCLES;
      next_hold_at <= next_hold_at + 800;
      res_ready_i <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      res_ready_i <= 1'b0;
    end else begin
      if (ready_stretch == 0) begin
        ready_free <= ($urandom_range(0, 3) == 0);
        ready_stretch <= $urandom_range(20, 150);
      end else begin
        ready_stretch <= ready_stretch - 1;
      end
      if (ready_free) begin
        res_ready_i <= 1'b1;
      end else if ($urandom_range(0, 99) < 3) begin
        stall_left <= $urandom_range(10, 40);
        res_ready_i <= 1'b0;
      end else begin
        res_ready_i <= ($urandom_range(0, 99) < 65);
      end
    end
  end

  task automatic send_item(bmhq_pkg::op_e op, bmhq_pkg::key_t key, bmhq_pkg::pay_t pay);
    req_valid_i <= 1'b1;
    operation_i <= op;
    key_i       <= key;
    payload_i   <= pay;
    do @(posedge clk_i); while (!req_ready_o);
  endtask

  task automatic idle_sender(int gap);
    if (gap > 0) begin
      req_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic wait_all_results();
    req_valid_i <= 1'b0;
    do @(posedge clk_i); while (res_count != req_count);
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // small keys give plenty of ties
  function automatic bmhq_pkg::key_t rand_key();
    case ($urandom_range(0, 9)) inside
      [0:3]: return bmhq_pkg::key_t'($urandom_range(0, 15));
      4: begin
        case ($urandom_range(0, 2))
          0:       return '0;
          1:       return '1;
          default: return 32'hFFFF_FFFE;
        endcase
      end
      default: return bmhq_pkg::key_t'($urandom());
    endcase
  endfunction

  function automatic bmhq_pkg::pay_t rand_pay();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return bmhq_pkg::pay_t'($urandom_range(0, 65535));
    endcase
  endfunction

  initial begin : stimulus
    int            sent;
    int            seg_len;
    int            pct;
    bit            no_gaps;
    bmhq_pkg::op_e op;
    sent = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // extract on empty, extreme keys and payloads, equal keys in order
    send_item(bmhq_pkg::OP_EXTRACT, '1, '1);
    send_item(bmhq_pkg::OP_INSERT, '1, '1);
    send_item(bmhq_pkg::OP_INSERT, '0, '0);
    send_item(bmhq_pkg::OP_INSERT, 32'd5, 16'd1);
    send_item(bmhq_pkg::OP_INSERT, 32'd5, 16'd2);
    send_item(bmhq_pkg::OP_INSERT, 32'd5, 16'd3);
    send_item(bmhq_pkg::OP_INSERT, 32'd5, 16'd4);
    send_item(bmhq_pkg::OP_INSERT, 32'd3, 16'hAAAA);
    send_item(bmhq_pkg::OP_INSERT, 32'd5, 16'h5555);
    repeat (9) send_item(bmhq_pkg::OP_EXTRACT, '0, '0);
    wait_all_results();

    while (sent < RANDOM_ITEMS) begin
      seg_len = $urandom_range(10, 80);
      case ($urandom_range(0, 3))
        0:       pct = 90;
        1:       pct = 15;
        2:       pct = 50;
        default: pct = $urandom_range(0, 100);
      endcase
      no_gaps = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < seg_len; i++) begin
        op = ($urandom_range(0, 99) < pct) ? bmhq_pkg::OP_INSERT : bmhq_pkg::OP_EXTRACT;
        send_item(op, rand_key(), rand_pay());
        sent++;
        if (!no_gaps) idle_sender(pick_gap());
      end
      if ($urandom_range(0, 5) == 0) wait_all_results();
    end

    wait_all_results();
    repeat (40) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
